// File: design/assert_macros.svh
// assertion macros shared by the sampler modules
// each macro expects clk and arst_n in scope of the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SCRS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scrs assertion failed");

// next-cycle implication, disabled during reset
`define SCRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scrs assertion failed");

`endif

// File: design/scrs_pkg.sv
// shared types and constants of the small coefficient rejection sampler
// no dependencies
`timescale 1ns / 1ps

package scrs_pkg;

	localparam int unsigned CoeffW  = 3;
	localparam int unsigned IdxW    = 10;
	localparam int unsigned CntW    = 11;
	localparam int unsigned MaxRun  = 5;
	localparam int unsigned RunW    = 3;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned CfgIdxW = 2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] RegEtaMode = 2'd0;
	localparam logic [CfgIdxW-1:0] RegTarget  = 2'd1;

	localparam logic [CntW-1:0] TargetReset = 11'd256;

	// eta mode codes
	localparam logic EtaOne = 1'b0;
	localparam logic EtaTwo = 1'b1;

	typedef logic signed [CoeffW-1:0] coeff_t;

	typedef struct packed {
		logic            eta_mode;
		logic [CntW-1:0] target;   // already saturated
	} cfg_t;

	// one queue entry: accepted coefficients of one item
	typedef struct packed {
		coeff_t [MaxRun-1:0] vals;
		logic [RunW-1:0]     n;     // 1..MaxRun
		logic [CntW-1:0]     base;  // count before the first coefficient
	} entry_t;

endpackage

// File: design/scrs_if.sv
// channel interfaces: random byte input, coefficient output, configuration writes
// depends on scrs_pkg
`timescale 1ns / 1ps

interface scrs_in_if;
	import scrs_pkg::*;
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] rand_byte;
	logic             restart;
	modport source (output valid, rand_byte, restart, input ready);
	modport sink (input valid, rand_byte, restart, output ready);
endinterface

interface scrs_out_if;
	import scrs_pkg::*;
	logic            valid;
	logic            ready;
	coeff_t          coeff;
	logic [IdxW-1:0] coeff_index;
	logic            last_of_run;
	logic            target_reached;
	modport source (output valid, coeff, coeff_index, last_of_run, target_reached,
		input ready);
	modport sink (input valid, coeff, coeff_index, last_of_run, target_reached,
		output ready);
endinterface

interface scrs_cfg_if;
	import scrs_pkg::*;
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [CntW-1:0]    wdata;
	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

// File: design/small_coefficient_rejection_sampler.sv
// top level of the small coefficient rejection sampler
// depends on scrs_pkg, scrs_if, scrs_front, scrs_fifo, scrs_back
`timescale 1ns / 1ps

// Turns a stream of random bytes into polynomial coefficients bounded by eta.
// With eta_mode 0 a byte below 243 splits into five base-3 digits, least
// significant first, mapped 0,1,2 to 0,1,-1; with eta_mode 1 the low then the
// high nibble is used, and a nibble below 15 gives 2 - (nibble mod 5).
// Rejected bytes or nibbles give nothing. Coefficients stop once the count
// reaches the configured target (saturated at MAX_COEFFS); restart on an item clears
// the count before that item is used. The input side takes one item per cycle
// while the two-entry run queue has room; the output side delivers one
// coefficient per cycle unless the receiver stalls it. An accepted eta-1 byte
// yields up to five coefficients, an eta-2 byte up to two, and a rejected
// byte none.
// Sustained rate is limited by the output side and by the receiver's ready.
// Configuration writes are always ready and take effect on the next cycle;
// write only while the sampler is idle.
module small_coefficient_rejection_sampler #(
	parameter int unsigned MAX_COEFFS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	scrs_in_if.sink     rnd,
	scrs_out_if.source  coef,
	scrs_cfg_if.sink    cfg
);
	import scrs_pkg::*;

	// configuration registers
	logic            eta_mode_q;
	logic [CntW-1:0] target_q;

	// target clipped at the polynomial size
	logic [CntW-1:0] target_eff;
	cfg_t            cfg_cur;

	// run queue between front and back
	entry_t          q_wdata;
	entry_t          q_head;
	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_mode_q <= EtaOne;
			target_q   <= TargetReset;
		end else if (cfg.valid) begin
			case (cfg.index)
				RegEtaMode: eta_mode_q <= cfg.wdata[0];
				RegTarget:  target_q   <= cfg.wdata;
				default: ;  // unknown index, dropped
			endcase
		end
	end

	// a target above MAX_COEFFS is clipped to MAX_COEFFS
	assign target_eff = (32'(target_q) > MAX_COEFFS) ? CntW'(MAX_COEFFS) : target_q;

	assign cfg_cur.eta_mode = eta_mode_q;
	assign cfg_cur.target   = target_eff;

	// front: classify each byte and reserve its coefficient indexes
	scrs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.rnd     (rnd),
		.cfg     (cfg_cur),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	scrs_fifo #(
		.DEPTH (2)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: one coefficient item per cycle from the head run, unless the output stalls
	scrs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef    (coef),
		.cfg     (cfg_cur),
		.head    (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop)
	);

endmodule

// File: design/scrs_front.sv
// front end: accepts random bytes, extracts candidate coefficients, trims to target
// depends on scrs_pkg, scrs_if, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scrs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	scrs_in_if.sink              rnd,
	input  scrs_pkg::cfg_t       cfg,
	input  logic                 q_full,
	output logic                 q_push,
	output scrs_pkg::entry_t     q_wdata
);
	import scrs_pkg::*;

	// candidate coefficients of one byte, packed from slot 0, and their count
	typedef struct packed {
		coeff_t [MaxRun-1:0] vals;
		logic [RunW-1:0]     n;
	} cand_t;

	function automatic cand_t classify(input logic [ByteW-1:0] b, input logic mode);
		cand_t           c;
		logic [7:0]      qd [6];
		logic [15:0]     prod;
		logic [1:0]      d;
		logic [3:0]      nib;
		logic [11:0]     np;
		logic [3:0]      nq;
		logic [2:0]      r;
		logic [RunW-1:0] k;
		c = '0;
		if (mode == EtaOne) begin
			if (b < 8'd243) begin
				// b / 3^i for every digit at once, each by its own reciprocal,
				// exact for bytes below 243
				qd[0] = b;
				prod = 16'(b) * 16'd171;
				qd[1] = 8'(prod >> 9);
				prod = 16'(b) * 16'd57;
				qd[2] = 8'(prod >> 9);
				prod = 16'(b) * 16'd19;
				qd[3] = 8'(prod >> 9);
				prod = 16'(b) * 16'd203;
				qd[4] = 8'(prod >> 14);
				qd[5] = 8'd0;
				for (int i = 0; i < 5; i++) begin
					// digit i is b / 3^i minus three times b / 3^(i+1)
					d = 2'(qd[i] - 8'(3 * qd[i+1]));
					case (d)
						2'd0: c.vals[i] = 3'sd0;
						2'd1: c.vals[i] = 3'sd1;
						default: c.vals[i] = -3'sd1;
					endcase
				end
				c.n = RunW'(MaxRun);
			end
		end else begin
			k = '0;
			for (int i = 0; i < 2; i++) begin
				nib = (i == 0) ? b[3:0] : b[7:4];
				np = 12'(nib) * 12'd205;
				nq = {2'b00, np[11:10]};
				r = 3'(nib - 4'(5 * nq));
				if (nib < 4'hf) begin
					c.vals[k] = 3'sd2 - coeff_t'(r);
					k = k + 1'b1;
				end
			end
			c.n = k;
		end
		return c;
	endfunction

	logic [CntW-1:0] count_q;
	logic [CntW-1:0] cnt_eff;
	logic [CntW-1:0] remaining;
	logic [RunW-1:0] n;
	logic            accept;
	cand_t           cand;

	assign rnd.ready = !q_full;
	assign accept    = rnd.valid && rnd.ready;
	assign cnt_eff   = rnd.restart ? '0 : count_q;
	assign remaining = (cnt_eff < cfg.target) ? cfg.target - cnt_eff : '0;
	assign cand      = classify(rnd.rand_byte, cfg.eta_mode);
	assign n         = (remaining < CntW'(cand.n)) ? remaining[RunW-1:0] : cand.n;

	assign q_push        = accept && (n != '0);
	assign q_wdata.vals  = cand.vals;
	assign q_wdata.n     = n;
	assign q_wdata.base  = cnt_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= cnt_eff + CntW'(n);
		end
	end

	`SCRS_ASSERT_IMPL(a_push_run_bounded, q_push, q_wdata.n <= RunW'(MaxRun))
	`SCRS_ASSERT_NEXT(a_count_follows, accept, count_q == $past(cnt_eff) + CntW'($past(n)))

endmodule

// File: design/scrs_fifo.sv
// short queue of per-item coefficient runs between front and back
// depends on scrs_pkg, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scrs_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  scrs_pkg::entry_t wdata,
	input  logic             pop,
	output scrs_pkg::entry_t rdata,
	output logic             full,
	output logic             empty
);
	import scrs_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FillW = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [FillW-1:0] fill_q;

	assign full  = (fill_q == FillW'(DEPTH));
	assign empty = (fill_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	`SCRS_ASSERT_IMPL(a_no_overflow, push, !full)
	`SCRS_ASSERT_IMPL(a_no_underflow, pop, !empty)

endmodule

// File: design/scrs_back.sv
// back end: walks each queued run and issues one coefficient per cycle unless the receiver stalls
// depends on scrs_pkg, scrs_if, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scrs_back (
	input  logic             clk,
	input  logic             arst_n,
	scrs_out_if.source       coef,
	input  scrs_pkg::cfg_t   cfg,
	input  scrs_pkg::entry_t head,
	input  logic             q_empty,
	output logic             q_pop
);
	import scrs_pkg::*;

	logic [RunW-1:0] k_q;
	logic            oval_q;
	coeff_t          coeff_q;
	logic [IdxW-1:0] idx_q;
	logic            last_q;
	logic            reached_q;

	logic            load;
	logic            issue;
	logic            run_end;
	logic [CntW-1:0] pos;

	assign load    = !oval_q || coef.ready;
	assign issue   = load && !q_empty;
	assign run_end = (k_q == head.n - 1'b1);
	assign pos     = head.base + CntW'(k_q);
	assign q_pop   = issue && run_end;

	assign coef.valid          = oval_q;
	assign coef.coeff          = coeff_q;
	assign coef.coeff_index    = idx_q;
	assign coef.last_of_run    = last_q;
	assign coef.target_reached = reached_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
			k_q    <= '0;
		end else if (load) begin
			oval_q <= issue;
			if (issue) begin
				k_q <= run_end ? '0 : k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			coeff_q   <= head.vals[k_q];
			idx_q     <= pos[IdxW-1:0];
			last_q    <= run_end;
			reached_q <= (pos + 1'b1) == cfg.target;
		end
	end

	`SCRS_ASSERT_IMPL(a_slot_in_run, !q_empty, k_q < head.n)
	`SCRS_ASSERT_NEXT(a_pop_marks_last, q_pop, oval_q && last_q)

endmodule
